/* hw/rtl/sfs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the sprite frame sequencer.
// No dependencies; used by sfs_advance and sprite_frame_sequencer.
package sfs_pkg;

  // Default geometry of the position word.
  localparam int unsigned FrameBitsDef = 10;
  localparam int unsigned FracBitsDef  = 8;

  // Fixed field widths.
  localparam int unsigned SpeedW   = 16;  // unsigned 8.8
  localparam int unsigned ScaleW   = 12;  // unsigned 4.8
  localparam int unsigned ProdW    = SpeedW + ScaleW;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned StateW   = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_TICK = 2'd0;
  localparam logic [ReqW-1:0] REQ_PLAY = 2'd1;
  localparam logic [ReqW-1:0] REQ_STOP = 2'd2;
  localparam logic [ReqW-1:0] REQ_SET  = 2'd3;

  // Run state codes.
  localparam logic [StateW-1:0] ST_STOPPED   = 2'd0;
  localparam logic [StateW-1:0] ST_PLAYING   = 2'd1;
  localparam logic [StateW-1:0] ST_REVERSING = 2'd2;
  localparam logic [StateW-1:0] ST_FINISHED  = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FIRST_FRAME = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_LAST_FRAME  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_SPEED = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PING_PONG   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LOOP_ENABLE = 3'd4;

  // Bound behavior flags.
  typedef struct packed {
    logic ping_pong;
    logic loop_enable;
  } sfs_mode_t;

endpackage

/* hw/rtl/sfs_advance.sv */
`timescale 1ns / 1ps
// Next-state logic of the sprite frame sequencer: applies one request to
// the position, direction and run state. Depends on sfs_pkg.
module sfs_advance #(
  parameter int unsigned FRAME_BITS = sfs_pkg::FrameBitsDef,
  parameter int unsigned FRAC_BITS  = sfs_pkg::FracBitsDef,
  parameter int unsigned STEP_W     = sfs_pkg::ProdW - FRAC_BITS + 1
) (
  input  logic [sfs_pkg::ReqW-1:0]          req_i,
  input  logic [STEP_W-1:0]                 step_i,
  input  logic [FRAME_BITS-1:0]             frame_i,
  input  logic [FRAME_BITS-1:0]             first_frame_i,
  input  logic [FRAME_BITS-1:0]             last_frame_i,
  input  sfs_pkg::sfs_mode_t                mode_i,
  input  logic [FRAME_BITS+FRAC_BITS:0]     pos_i,
  input  logic                              back_i,
  input  logic [sfs_pkg::StateW-1:0]        state_i,
  output logic [FRAME_BITS+FRAC_BITS:0]     pos_o,
  output logic                              back_o,
  output logic [sfs_pkg::StateW-1:0]        state_o,
  output logic signed [FRAME_BITS:0]        frame_index_o,
  output logic signed [FRAME_BITS+1:0]      frame_in_anim_o
);

  localparam int unsigned PosW  = FRAME_BITS + FRAC_BITS + 1;
  localparam int unsigned WideW = (PosW > STEP_W) ? PosW : STEP_W;
  localparam int unsigned SumW  = WideW + 2;

  logic [PosW-1:0]       first_pos, last_pos, frame_pos;
  logic [FRAME_BITS:0]   last_p1;
  logic signed [SumW-1:0] pos_ext, step_ext, next_sum, hi_lim, lo_lim;
  logic                  hi_hit, lo_hit, ovf;
  logic [PosW-1:0]       sat_pos;
  logic signed [PosW:0]  biased;

  assign first_pos = {1'b0, first_frame_i, {FRAC_BITS{1'b0}}};
  assign last_pos  = {1'b0, last_frame_i, {FRAC_BITS{1'b0}}};
  assign frame_pos = {1'b0, frame_i, {FRAC_BITS{1'b0}}};
  assign last_p1   = {1'b0, last_frame_i} + {{FRAME_BITS{1'b0}}, 1'b1};

  assign pos_ext  = {{(SumW-PosW){pos_i[PosW-1]}}, pos_i};
  assign step_ext = {{(SumW-STEP_W){1'b0}}, step_i};
  assign next_sum = back_i ? (pos_ext - step_ext) : (pos_ext + step_ext);
  assign hi_lim   = {{(SumW-FRAME_BITS-1-FRAC_BITS){1'b0}}, last_p1, {FRAC_BITS{1'b0}}};
  assign lo_lim   = {{(SumW-FRAME_BITS-FRAC_BITS){1'b0}}, first_frame_i,
                     {FRAC_BITS{1'b0}}};
  assign hi_hit   = !back_i && (next_sum >= hi_lim);
  assign lo_hit   = back_i && (next_sum < lo_lim);

  // Overflow when the bits above the position sign disagree with it.
  assign ovf = (next_sum[SumW-1:PosW-1] != {(SumW-PosW+1){1'b0}}) &&
               (next_sum[SumW-1:PosW-1] != {(SumW-PosW+1){1'b1}});
  assign sat_pos = !ovf ? next_sum[PosW-1:0]
                 : (next_sum[SumW-1] ? {1'b1, {(PosW-1){1'b0}}}
                                     : {1'b0, {(PosW-1){1'b1}}});

  always_comb begin
    pos_o   = pos_i;
    back_o  = back_i;
    state_o = state_i;
    unique case (req_i)
      sfs_pkg::REQ_TICK: begin
        if (state_i == sfs_pkg::ST_PLAYING || state_i == sfs_pkg::ST_REVERSING) begin
          if (hi_hit) begin
            if (mode_i.ping_pong) begin
              back_o  = 1'b1;
              pos_o   = last_pos;
              state_o = sfs_pkg::ST_REVERSING;
            end else if (mode_i.loop_enable) begin
              pos_o = first_pos;
            end else begin
              pos_o   = last_pos;
              state_o = sfs_pkg::ST_FINISHED;
            end
          end else if (lo_hit) begin
            pos_o = first_pos;
            if (mode_i.loop_enable) begin
              back_o  = 1'b0;
              state_o = sfs_pkg::ST_PLAYING;
            end else begin
              state_o = sfs_pkg::ST_FINISHED;
            end
          end else begin
            pos_o = sat_pos;
          end
        end
      end
      sfs_pkg::REQ_PLAY: begin
        pos_o   = first_pos;
        back_o  = 1'b0;
        state_o = sfs_pkg::ST_PLAYING;
      end
      sfs_pkg::REQ_STOP: begin
        state_o = sfs_pkg::ST_STOPPED;
      end
      sfs_pkg::REQ_SET: begin
        pos_o = frame_pos;
      end
      default: begin
        pos_o = pos_i;
      end
    endcase
  end

  // Integer part truncated toward zero: bias negative values before the shift.
  assign biased = $signed({pos_o[PosW-1], pos_o}) +
                  $signed({{(PosW-FRAC_BITS+1){1'b0}},
                           {FRAC_BITS{pos_o[PosW-1]}}});
  assign frame_index_o   = biased[FRAC_BITS+FRAME_BITS:FRAC_BITS];
  assign frame_in_anim_o = $signed({frame_index_o[FRAME_BITS], frame_index_o})
                         - $signed({2'b00, first_frame_i})
                         + $signed({{(FRAME_BITS+1){1'b0}}, 1'b1});

endmodule

/* hw/rtl/sprite_frame_sequencer.sv */
`timescale 1ns / 1ps
// Top level of the sprite frame sequencer: configuration registers,
// input and result registers, position state. Depends on sfs_pkg, sfs_advance.
//
// Usage. Configuration words arrive on the cfg channel (index 0 first frame,
// 1 last frame, 2 speed in 8.8, 3 ping-pong, 4 loop); cfg_ready_o is always
// high, and writes to unused indexes are dropped. Configuration is meant to
// change only while no request is in flight.
// Each request word on the input channel produces exactly one result word.
// The accept edge loads the input register with speed times time scale,
// multiplied and rounded; the first edge after that on which advance is high
// applies the step to the position state and loads the result register.
// Throughput is one word per cycle while out_ready_i stays high. The limit
// is the position feedback loop, one add, one bound compare and a select.
// When the receiver stalls, the result register holds its word and the
// input register holds one more; in_ready_o drops only when both are full
// and out_ready_i is low.
// Reset clears the valid flags, sets first and last frame to 1, speed and
// flags to zero, position to frame 1.0, forward direction, state stopped.
module sprite_frame_sequencer #(
  parameter int unsigned FRAME_BITS = sfs_pkg::FrameBitsDef,
  parameter int unsigned FRAC_BITS  = sfs_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration channel.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sfs_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sfs_pkg::CfgDataW-1:0]      cfg_data_i,
  // Request channel.
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [sfs_pkg::ReqW-1:0]          req_type_i,
  input  logic [sfs_pkg::ScaleW-1:0]        time_scale_i,
  input  logic [FRAME_BITS-1:0]             frame_value_i,
  // Result channel.
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [FRAME_BITS:0]        frame_index_o,
  output logic signed [FRAME_BITS+1:0]      frame_in_anim_o,
  output logic [sfs_pkg::StateW-1:0]        run_state_o
);

  localparam int unsigned PosW  = FRAME_BITS + FRAC_BITS + 1;
  localparam int unsigned StepW = sfs_pkg::ProdW - FRAC_BITS + 1;

  // Configuration registers.
  logic [FRAME_BITS-1:0]          first_frame_q, last_frame_q;
  logic [sfs_pkg::SpeedW-1:0]     frame_speed_q;
  sfs_pkg::sfs_mode_t             mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_frame_q <= FRAME_BITS'(1);
      last_frame_q  <= FRAME_BITS'(1);
      frame_speed_q <= '0;
      mode_q        <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sfs_pkg::CFG_FIRST_FRAME: first_frame_q <= cfg_data_i[FRAME_BITS-1:0];
        sfs_pkg::CFG_LAST_FRAME:  last_frame_q  <= cfg_data_i[FRAME_BITS-1:0];
        sfs_pkg::CFG_FRAME_SPEED: frame_speed_q <= cfg_data_i;
        sfs_pkg::CFG_PING_PONG:   mode_q.ping_pong   <= cfg_data_i[0];
        sfs_pkg::CFG_LOOP_ENABLE: mode_q.loop_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Input register. The step is rounded here so the state loop sees only
  // an add and a compare.
  logic                          in_valid_q;
  logic [sfs_pkg::ReqW-1:0]      req_q;
  logic [StepW-1:0]              step_q, step_d;
  logic [FRAME_BITS-1:0]         frame_q;
  logic [sfs_pkg::ProdW-1:0]     prod;
  logic [sfs_pkg::ProdW:0]       prod_rnd;
  logic                          advance;

  assign prod     = frame_speed_q * time_scale_i;
  assign prod_rnd = {1'b0, prod} + {{(sfs_pkg::ProdW-FRAC_BITS+1){1'b0}}, 1'b1,
                                    {(FRAC_BITS-1){1'b0}}};
  assign step_d   = prod_rnd[sfs_pkg::ProdW:FRAC_BITS];

  // The state stage moves whenever the input register holds a request and the result register is free or drains.
  assign advance    = in_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q   <= req_type_i;
      step_q  <= step_d;
      frame_q <= frame_value_i;
    end
  end

  // Position state and result register.
  logic [PosW-1:0]               pos_q, pos_d;
  logic                          back_q, back_d;
  logic [sfs_pkg::StateW-1:0]    state_q, state_d;
  logic signed [FRAME_BITS:0]    frame_index_d;
  logic signed [FRAME_BITS+1:0]  frame_in_anim_d;
  logic                          out_valid_q;

  sfs_advance #(
    .FRAME_BITS (FRAME_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .STEP_W     (StepW)
  ) u_advance (
    .req_i           (req_q),
    .step_i          (step_q),
    .frame_i         (frame_q),
    .first_frame_i   (first_frame_q),
    .last_frame_i    (last_frame_q),
    .mode_i          (mode_q),
    .pos_i           (pos_q),
    .back_i          (back_q),
    .state_i         (state_q),
    .pos_o           (pos_d),
    .back_o          (back_d),
    .state_o         (state_d),
    .frame_index_o   (frame_index_d),
    .frame_in_anim_o (frame_in_anim_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= {1'b0, {(FRAME_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
      back_q      <= 1'b0;
      state_q     <= sfs_pkg::ST_STOPPED;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        pos_q   <= pos_d;
        back_q  <= back_d;
        state_q <= state_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      frame_index_o   <= frame_index_d;
      frame_in_anim_o <= frame_in_anim_d;
      run_state_o     <= state_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
